// ===== rtl/virtual_page_bitmap_allocator_assert.svh =====
// Assertion macros used by the port-level checker of the page bitmap allocator.
`ifndef VIRTUAL_PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define VIRTUAL_PAGE_BITMAP_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/vpba_pkg.sv =====
// Types, constants and helper functions of the page bitmap allocator.
package vpba_pkg;

   localparam int PAGE_W            = 10;
   localparam int RUN_W             = 11;
   localparam int CMD_W             = 2;
   localparam int STAT_W            = 3;
   localparam int WORD_BITS         = 32;
   localparam int BIT_W             = 5;
   localparam int PAGE_LIMIT        = 1024;
   localparam int DEFAULT_NUM_PAGES = 1024;

   localparam logic [PAGE_W-1:0] RESET_START_PAGE = PAGE_W'(768);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC_ANY = 2'd0,
      CMD_ALLOC_AT  = 2'd1,
      CMD_ALLOC_RUN = 2'd2,
      CMD_FREE      = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK          = 3'd0,
      ST_NO_SPACE    = 3'd1,
      ST_BUSY        = 3'd2,
      ST_DOUBLE_FREE = 3'd3,
      ST_BAD_ARG     = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [PAGE_W-1:0] page_num;
      logic [RUN_W-1:0]  run_length;
      logic [PAGE_W-1:0] start_page;
   } job_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      status_type        status;
   } result_type;

   // Position of the lowest set bit, or WORD_BITS when no bit is set.
   function automatic logic [BIT_W:0] first_one(input logic [WORD_BITS-1:0] v);
      logic [BIT_W:0] pos;
      pos = (BIT_W+1)'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = (BIT_W+1)'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ===== rtl/vpba_engine.sv =====
// Bitmap memory and the word-serial search, check and mark sequencer.
module vpba_engine #(
   parameter int NUM_PAGES = vpba_pkg::DEFAULT_NUM_PAGES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  vpba_pkg::job_type    job,
   output logic                 idle,
   input  logic                 out_free,
   output logic                 done,
   output vpba_pkg::result_type result
);
   import vpba_pkg::*;

   localparam int USABLE  = (NUM_PAGES < PAGE_LIMIT) ? NUM_PAGES : PAGE_LIMIT;
   localparam int WORDS   = (USABLE + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW = $clog2(WORDS);
   localparam int TAIL    = USABLE % WORD_BITS;
   localparam logic [WORD_BITS-1:0] TAIL_MASK =
      (TAIL == 0) ? '1 : WORD_BITS'((64'(1) << TAIL) - 64'(1));
   localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);
   localparam logic [PAGE_W:0]    USABLE_L  = (PAGE_W+1)'(USABLE);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_FETCH = 6'b000010,
      S_SCAN  = 6'b000100,
      S_CHECK = 6'b001000,
      S_MARK  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [PAGE_W-1:0]    idx_ff, idx_in;
   logic [RUN_W-1:0]     len_ff, len_in;
   logic [WORD_AW-1:0]   word_ff, word_in;
   logic [BIT_W-1:0]     lo_ff, lo_in;
   logic [RUN_W-1:0]     count_ff, count_in;
   logic [PAGE_W-1:0]    first_ff, first_in;
   logic [RUN_W-1:0]     remain_ff, remain_in;
   logic                 marking_ff, marking_in;
   logic [PAGE_W-1:0]    res_page_ff, res_page_in;
   status_type           res_status_ff, res_status_in;

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORDS-1:0]     valid_ff;
   logic [WORD_BITS-1:0] rd_ff;
   logic                 rd_valid_ff;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;

   logic [WORD_BITS-1:0] cur_word, eff_word, free_ge, used_ge, bit_mask, mark_mask;
   logic [BIT_W:0]       s_pos, u_pos, seg, room, mark_n, mark_hi;
   logic                 found, run_hit, bit_used;
   logic [RUN_W:0]       total;
   logic [PAGE_W-1:0]    word_base, s_page, cand_first, start_eff;
   logic [RUN_W-1:0]     job_len, remain_next;
   logic [WORD_AW-1:0]   word_next;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[word_ff] <= wr_data;
      end
      rd_ff       <= mem[word_ff];
      rd_valid_ff <= valid_ff[word_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[word_ff] <= 1'b1;
      end
   end

   always_comb begin
      cur_word  = rd_valid_ff ? rd_ff : '0;
      eff_word  = cur_word | ~((word_ff == LAST_WORD) ? TAIL_MASK : '1);
      free_ge   = ~eff_word & ({WORD_BITS{1'b1}} << lo_ff);
      found     = (count_ff != '0) || (|free_ge);
      s_pos     = (count_ff != '0) ? {1'b0, lo_ff} : first_one(free_ge);
      used_ge   = eff_word & ({WORD_BITS{1'b1}} << s_pos[BIT_W-1:0]);
      u_pos     = first_one(used_ge);
      seg       = u_pos - s_pos;
      total     = {1'b0, count_ff} + (RUN_W+1)'(seg);
      run_hit   = total >= {1'b0, len_ff};
      word_base = PAGE_W'({word_ff, BIT_W'(0)});
      s_page    = word_base | PAGE_W'(s_pos[BIT_W-1:0]);
      cand_first = (count_ff != '0) ? first_ff : s_page;
      word_next = word_ff + WORD_AW'(1);

      bit_mask  = WORD_BITS'(1) << idx_ff[BIT_W-1:0];
      bit_used  = |(cur_word & bit_mask);

      room      = (BIT_W+1)'(WORD_BITS) - {1'b0, lo_ff};
      mark_n    = (remain_ff < RUN_W'(room)) ? (BIT_W+1)'(remain_ff) : room;
      mark_hi   = {1'b0, lo_ff} + mark_n;
      for (int i = 0; i < WORD_BITS; i++) begin
         mark_mask[i] = ((BIT_W+1)'(i) >= {1'b0, lo_ff}) && ((BIT_W+1)'(i) < mark_hi);
      end
      remain_next = remain_ff - RUN_W'(mark_n);

      start_eff = (job.start_page == '0) ? PAGE_W'(1) : job.start_page;
      job_len   = (job.cmd == CMD_ALLOC_ANY) ? RUN_W'(1) : job.run_length;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      word_in       = word_ff;
      lo_in         = lo_ff;
      count_in      = count_ff;
      first_in      = first_ff;
      remain_in     = remain_ff;
      marking_in    = marking_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_data       = cur_word;
      done          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               cmd_in        = job.cmd;
               idx_in        = job.page_num;
               len_in        = job_len;
               count_in      = '0;
               marking_in    = 1'b0;
               res_page_in   = '0;
               res_status_in = ST_OK;
               if (job.cmd == CMD_ALLOC_AT || job.cmd == CMD_FREE) begin
                  if (job.page_num == '0 || {1'b0, job.page_num} >= USABLE_L) begin
                     res_status_in = ST_BAD_ARG;
                     state_in      = S_DONE;
                  end else begin
                     word_in  = WORD_AW'(job.page_num[PAGE_W-1:BIT_W]);
                     state_in = S_FETCH;
                  end
               end else if (job_len == '0) begin
                  res_status_in = ST_BAD_ARG;
                  state_in      = S_DONE;
               end else if ({1'b0, start_eff} >= USABLE_L) begin
                  res_status_in = ST_NO_SPACE;
                  state_in      = S_DONE;
               end else begin
                  word_in  = WORD_AW'(start_eff[PAGE_W-1:BIT_W]);
                  lo_in    = start_eff[BIT_W-1:0];
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (cmd_ff == CMD_ALLOC_AT || cmd_ff == CMD_FREE) begin
               state_in = S_CHECK;
            end else if (marking_ff) begin
               state_in = S_MARK;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (found && run_hit) begin
               first_in   = cand_first;
               marking_in = 1'b1;
               word_in    = WORD_AW'(cand_first[PAGE_W-1:BIT_W]);
               lo_in      = cand_first[BIT_W-1:0];
               remain_in  = len_ff;
               state_in   = S_FETCH;
            end else if (found && !u_pos[BIT_W]) begin
               count_in = '0;
               lo_in    = u_pos[BIT_W-1:0];
            end else begin
               count_in = found ? total[RUN_W-1:0] : '0;
               first_in = cand_first;
               if (word_ff == LAST_WORD) begin
                  res_status_in = ST_NO_SPACE;
                  state_in      = S_DONE;
               end else begin
                  word_in  = word_next;
                  lo_in    = '0;
                  state_in = S_FETCH;
               end
            end
         end
         S_CHECK: begin
            state_in = S_DONE;
            if (cmd_ff == CMD_ALLOC_AT) begin
               if (bit_used) begin
                  res_status_in = ST_BUSY;
               end else begin
                  wr_en       = 1'b1;
                  wr_data     = cur_word | bit_mask;
                  res_page_in = idx_ff;
               end
            end else begin
               if (!bit_used) begin
                  res_status_in = ST_DOUBLE_FREE;
               end else begin
                  wr_en       = 1'b1;
                  wr_data     = cur_word & ~bit_mask;
                  res_page_in = idx_ff;
               end
            end
         end
         S_MARK: begin
            wr_en     = 1'b1;
            wr_data   = cur_word | mark_mask;
            remain_in = remain_next;
            if (remain_next == '0) begin
               res_page_in = first_ff;
               state_in    = S_DONE;
            end else begin
               word_in  = word_next;
               lo_in    = '0;
               state_in = S_FETCH;
            end
         end
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      len_ff        <= len_in;
      word_ff       <= word_in;
      lo_ff         <= lo_in;
      count_ff      <= count_in;
      first_ff      <= first_in;
      remain_ff     <= remain_in;
      marking_ff    <= marking_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
   end

   assign idle          = (state_ff == S_IDLE);
   assign result.page   = res_page_ff;
   assign result.status = res_status_ff;

endmodule

// ===== rtl/virtual_page_bitmap_allocator.sv =====
// Top level of the first-fit virtual page bitmap allocator.
// One command is taken at a time; req_ready is low during reset and stays low
// until the command's word is loaded into the response register, which holds
// it while the next command is already taken. A rejected command, or a search
// whose start page lies beyond the pool, goes from acceptance straight to the
// done step, which loads its response word. Alloc-at and free go through one
// bitmap read, one read-modify-write and the load of the response register.
// Alloc-any and alloc-run read the bitmap one 32-page word at a time through
// a single port, each word fetched and then scanned, with one more scan step
// for each free stretch that a used page ends inside a word; marking the
// found page or run fetches and then marks each word it touches, and a last
// step loads the response register. With the default pool a search is
// bounded by 32 word reads. The engine returns to idle as the response
// register is loaded, and a stalled response register holds the engine in
// its last step. The bitmap needs no clearing pass after reset: a valid bit
// per word makes unwritten words read as free.
module virtual_page_bitmap_allocator #(
   parameter int NUM_PAGES = vpba_pkg::DEFAULT_NUM_PAGES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [vpba_pkg::CMD_W-1:0]    req_cmd,
   input  logic [vpba_pkg::PAGE_W-1:0]   req_page_num,
   input  logic [vpba_pkg::RUN_W-1:0]    req_run_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vpba_pkg::PAGE_W-1:0]   rsp_result_page,
   output logic [vpba_pkg::STAT_W-1:0]   rsp_status,
   input  logic                          csr_write_enable,
   input  logic [vpba_pkg::PAGE_W-1:0]   csr_search_start_page
);
   import vpba_pkg::*;

   logic [PAGE_W-1:0] start_ff, start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0] rsp_page_ff, rsp_page_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   job_type    job;
   result_type result;
   logic       eng_idle, eng_done, out_free;

   assign job.cmd        = cmd_type'(req_cmd);
   assign job.page_num   = req_page_num;
   assign job.run_length = req_run_length;
   assign job.start_page = start_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = eng_idle && !reset;

   vpba_engine #(
      .NUM_PAGES (NUM_PAGES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .job_valid (req_valid && req_ready),
      .job       (job),
      .idle      (eng_idle),
      .out_free  (out_free),
      .done      (eng_done),
      .result    (result)
   );

   always_comb begin
      start_in      = csr_write_enable ? csr_search_start_page : start_ff;
      rsp_valid_in  = eng_done ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_page_in   = eng_done ? result.page : rsp_page_ff;
      rsp_status_in = eng_done ? STAT_W'(result.status) : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= RESET_START_PAGE;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== rtl/vpba_checker.sv =====
// Port-level checker of the page bitmap allocator and its bind.
`include "virtual_page_bitmap_allocator_assert.svh"

module vpba_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [vpba_pkg::PAGE_W-1:0] rsp_result_page,
   input logic [vpba_pkg::STAT_W-1:0] rsp_status
);
   import vpba_pkg::*;

   `VPBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after a command was taken")
   `VPBA_ASSERT_SAME(a_fail_page_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_result_page == '0, "failed word carries a nonzero page")
   `VPBA_ASSERT_SAME(a_ok_page_nonzero, clock, reset, rsp_valid && rsp_status == ST_OK, rsp_result_page != '0, "successful word carries page zero")
   `VPBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_page) && $stable(rsp_status), "stalled response word changed")

endmodule

bind virtual_page_bitmap_allocator vpba_checker u_vpba_checker (.*);

// ===== tb/sv/page_allocator_checker.sv =====
// Checker that predicts and compares every response word of the page bitmap allocator.
`timescale 1ns / 100ps

module page_allocator_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [vpba_pkg::CMD_W-1:0]  req_cmd,
   input  logic [vpba_pkg::PAGE_W-1:0] req_page_num,
   input  logic [vpba_pkg::RUN_W-1:0]  req_run_length,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [vpba_pkg::PAGE_W-1:0] rsp_result_page,
   input  logic [vpba_pkg::STAT_W-1:0] rsp_status,
   input  logic                        csr_write_enable,
   input  logic [vpba_pkg::PAGE_W-1:0] csr_search_start_page,
   output int                          fail_count,
   output int                          expected_count
);
   import vpba_pkg::*;

   localparam int POOL_PAGES   = DEFAULT_NUM_PAGES < PAGE_LIMIT ? DEFAULT_NUM_PAGES : PAGE_LIMIT;
   localparam int BITMAP_WORDS = (DEFAULT_NUM_PAGES + WORD_BITS - 1) / WORD_BITS;

   logic [WORD_BITS-1:0] page_bitmap [BITMAP_WORDS];
   logic [PAGE_W-1:0]    start_page;
   result_type           pending_results [$];
   result_type           oldest;
   int                   mismatches = 0;

   function automatic bit page_taken(int p);
      return page_bitmap[p / WORD_BITS][p % WORD_BITS];
   endfunction

   function automatic void set_page(int p, logic used);
      page_bitmap[p / WORD_BITS][p % WORD_BITS] = used;
   endfunction

   function automatic result_type allocate_pages(cmd_type cmd, logic [PAGE_W-1:0] idx,
                                                 logic [RUN_W-1:0] len);
      result_type r;
      int first;
      int i;
      int count;
      int run_first;
      r.page = '0;
      r.status = ST_OK;
      first = (start_page == '0) ? 1 : int'(start_page);
      case (cmd)
         CMD_ALLOC_ANY: begin
            r.status = ST_NO_SPACE;
            for (i = first; i < POOL_PAGES && r.status != ST_OK; i++) begin
               if (!page_taken(i)) begin
                  set_page(i, 1'b1);
                  r.page = PAGE_W'(i);
                  r.status = ST_OK;
               end
            end
         end
         CMD_ALLOC_AT: begin
            if (idx == '0 || int'(idx) >= POOL_PAGES) begin
               r.status = ST_BAD_ARG;
            end else if (page_taken(int'(idx))) begin
               r.status = ST_BUSY;
            end else begin
               set_page(int'(idx), 1'b1);
               r.page = idx;
            end
         end
         CMD_ALLOC_RUN: begin
            if (len == '0) begin
               r.status = ST_BAD_ARG;
            end else begin
               count = 0;
               run_first = 0;
               for (i = first; i < POOL_PAGES && count < int'(len); i++) begin
                  if (page_taken(i)) begin
                     count = 0;
                  end else begin
                     if (count == 0) begin
                        run_first = i;
                     end
                     count++;
                  end
               end
               if (count == int'(len)) begin
                  for (i = 0; i < int'(len); i++) begin
                     set_page(run_first + i, 1'b1);
                  end
                  r.page = PAGE_W'(run_first);
               end else begin
                  r.status = ST_NO_SPACE;
               end
            end
         end
         default: begin
            if (idx == '0 || int'(idx) >= POOL_PAGES) begin
               r.status = ST_BAD_ARG;
            end else if (!page_taken(int'(idx))) begin
               r.status = ST_DOUBLE_FREE;
            end else begin
               set_page(int'(idx), 1'b0);
               r.page = idx;
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
      if (mismatches < 40) begin
         $display("%0t checker: %s mismatch, expected %0d got %0d", $time, field, want, got);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (page_bitmap[w]) begin
            page_bitmap[w] = '0;
         end
         start_page = RESET_START_PAGE;
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected response word, page", '0, 16'(rsp_result_page));
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_result_page !== oldest.page) begin
                  report_mismatch("result_page", 16'(oldest.page), 16'(rsp_result_page));
               end
               if (rsp_status !== oldest.status) begin
                  report_mismatch("status", 16'(oldest.status), 16'(rsp_status));
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(allocate_pages(cmd_type'(req_cmd), req_page_num,
                                                     req_run_length));
         end
         if (csr_write_enable) begin
            start_page = csr_search_start_page;
         end
      end
      fail_count <= mismatches;
      expected_count <= pending_results.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the page bitmap allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
   import vpba_pkg::*;

   localparam int LONG_HOLD = 400;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = CMD_ALLOC_ANY;
   logic [PAGE_W-1:0]   req_page_num = '0;
   logic [RUN_W-1:0]    req_run_length = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [PAGE_W-1:0]   rsp_result_page;
   logic [STAT_W-1:0]   rsp_status;
   logic                csr_write_enable = 1'b0;
   logic [PAGE_W-1:0]   csr_search_start_page = RESET_START_PAGE;
   int                  fail_count;
   int                  expected_count;

   bit                  steady = 1'b0;
   int                  hold_requests = 0;
   int                  holds_done = 0;
   logic [PAGE_W-1:0]   freeable_pages [$];
   job_type             issued_jobs [$];

   virtual_page_bitmap_allocator DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_page_num          (req_page_num),
      .req_run_length        (req_run_length),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_page       (rsp_result_page),
      .rsp_status            (rsp_status),
      .csr_write_enable      (csr_write_enable),
      .csr_search_start_page (csr_search_start_page)
   );

   page_allocator_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_page_num          (req_page_num),
      .req_run_length        (req_run_length),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_page       (rsp_result_page),
      .rsp_status            (rsp_status),
      .csr_write_enable      (csr_write_enable),
      .csr_search_start_page (csr_search_start_page),
      .fail_count            (fail_count),
      .expected_count        (expected_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   // Pages that came back allocated are kept so that frees mostly hit used pages.
   always @(posedge clock) begin : track_allocations
      job_type done;
      int span;
      if (reset) begin
         issued_jobs.delete();
         freeable_pages.delete();
      end else begin
         if (rsp_valid && rsp_ready && issued_jobs.size() != 0) begin
            done = issued_jobs.pop_front();
            if (rsp_status == ST_OK && done.cmd != CMD_FREE) begin
               span = (done.cmd == CMD_ALLOC_RUN) ? int'(done.run_length) : 1;
               for (int k = 0; k < span; k++) begin
                  freeable_pages.push_back(PAGE_W'(int'(rsp_result_page) + k));
               end
            end
         end
         if (req_valid && req_ready) begin
            issued_jobs.push_back('{cmd_type'(req_cmd), req_page_num, req_run_length,
                                    csr_search_start_page});
         end
      end
   end

   initial begin : receiver
      int ready_left;
      int stall_left;
      ready_left = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            stall_left = LONG_HOLD;
            ready_left = 0;
         end else if (stall_left == 0 && ready_left == 0) begin
            stall_left = gap_length();
            ready_left = $urandom_range(1, 24);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            ready_left--;
         end
      end
   end

   task automatic send_command(cmd_type cmd, logic [PAGE_W-1:0] page, logic [RUN_W-1:0] run);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_page_num <= page;
      req_run_length <= run;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [RUN_W-1:0] pick_run_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         return '0;
      end else if (r < 73) begin
         return RUN_W'($urandom_range(1, 8));
      end else if (r < 93) begin
         return RUN_W'($urandom_range(9, 32));
      end else if (r < 96) begin
         return RUN_W'($urandom_range(33, 1023));
      end
      return RUN_W'($urandom_range(1024, 2047));
   endfunction

   task automatic send_random_command();
      int r;
      int free_share;
      int j;
      logic [PAGE_W-1:0] page;
      r = $urandom_range(0, 99);
      free_share = (freeable_pages.size() > 300) ? 60 : 35;
      page = PAGE_W'($urandom_range(0, 1023));
      if (r < free_share) begin
         if (freeable_pages.size() != 0 && $urandom_range(0, 3) != 0) begin
            j = $urandom_range(0, freeable_pages.size() - 1);
            page = freeable_pages[j];
            freeable_pages.delete(j);
         end
         send_command(CMD_FREE, page, RUN_W'($urandom));
      end else if (r < free_share + 22) begin
         send_command(CMD_ALLOC_ANY, page, RUN_W'($urandom));
      end else if (r < free_share + 42) begin
         if (freeable_pages.size() != 0 && $urandom_range(0, 1) != 0) begin
            page = freeable_pages[$urandom_range(0, freeable_pages.size() - 1)];
         end
         send_command(CMD_ALLOC_AT, page, RUN_W'($urandom));
      end else begin
         send_command(CMD_ALLOC_RUN, page, pick_run_length());
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_count != 0);
   endtask

   task automatic write_start_page(logic [PAGE_W-1:0] start);
      csr_write_enable <= 1'b1;
      csr_search_start_page <= start;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      int phase_starts [7];
      phase_starts = '{0, 1023, 1, 512, 1000, 64, 768};
      phase_starts[3] = $urandom_range(0, 1023);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_command(CMD_ALLOC_ANY, '0, '0);
      send_command(CMD_ALLOC_ANY, '1, '1);
      send_command(CMD_ALLOC_AT, 10'd0, '0);
      send_command(CMD_ALLOC_AT, 10'd1023, '0);
      send_command(CMD_ALLOC_AT, 10'd1023, '0);
      send_command(CMD_ALLOC_AT, 10'd768, '0);
      send_command(CMD_FREE, 10'd0, '0);
      send_command(CMD_FREE, 10'd1023, '0);
      send_command(CMD_FREE, 10'd1023, '0);
      send_command(CMD_ALLOC_RUN, '0, 11'd0);
      send_command(CMD_ALLOC_RUN, '0, 11'd2047);
      send_command(CMD_ALLOC_RUN, '0, 11'd1024);
      send_command(CMD_ALLOC_RUN, '0, 11'd255);
      send_command(CMD_ALLOC_RUN, '0, 11'd254);
      send_command(CMD_ALLOC_ANY, '0, '0);
      send_command(CMD_FREE, 10'd900, '0);
      send_command(CMD_ALLOC_ANY, '0, '0);
      send_command(CMD_ALLOC_AT, 10'd1, '0);
      send_command(CMD_FREE, 10'd1, '0);
      send_command(CMD_ALLOC_AT, 10'd767, '0);
      send_command(CMD_ALLOC_RUN, '0, 11'd1);

      for (int ph = 0; ph < 7; ph++) begin
         drain_results();
         write_start_page(PAGE_W'(phase_starts[ph]));
         send_command(CMD_ALLOC_ANY, '0, '0);
         send_command(CMD_ALLOC_RUN, '0, 11'd1);
         if (ph == 2) begin
            steady = 1'b1;
            hold_requests++;
            repeat (10) send_random_command();
            steady = 1'b0;
         end
         repeat (72) send_random_command();
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && expected_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
